// ----- src/dect_pkg.sv -----
// Package for the directed edge cancel table: widths, mode and status codes.
// No dependencies.
`default_nettype none
package dect_pkg;
  localparam int TableDepth = 1024;
  localparam int VertexBits = 16;
  localparam int AddrW = $clog2(TableDepth);
  localparam int CntW = AddrW + 1;

  localparam logic [2:0] MODE_ADD = 3'd0;
  localparam logic [2:0] MODE_ADD_NR = 3'd1;
  localparam logic [2:0] MODE_ADD_NOREV = 3'd2;
  localparam logic [2:0] MODE_ADD_ABSENT = 3'd3;
  localparam logic [2:0] MODE_NEXT = 3'd4;
  localparam logic [2:0] MODE_CLEAR = 3'd5;

  localparam logic [2:0] ST_APPENDED = 3'd0;
  localparam logic [2:0] ST_CANCELLED = 3'd1;
  localparam logic [2:0] ST_IGNORED = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;
  localparam logic [2:0] ST_FOUND = 3'd4;
  localparam logic [2:0] ST_NONE = 3'd5;

  typedef logic [VertexBits-1:0] vtx_t;

  typedef struct packed {
    vtx_t from;
    vtx_t to;
    logic visited;
  } live_t;

  typedef struct packed {
    logic we;
    logic [AddrW-1:0] waddr;
    live_t wdata;
    logic [AddrW-1:0] raddr;
  } live_port_t;
endpackage
`default_nettype wire

// ----- src/dect_live_mem.sv -----
// Live edge table memory: one write port and one registered read port.
// Depends on dect_pkg.
`default_nettype none
module dect_live_mem
  import dect_pkg::*;
(
  input  wire logic       clk,
  input  wire live_port_t port,
  output live_t           rdata
);
  live_t mem [TableDepth];

  always_ff @(posedge clk) begin
    if (port.we) begin
      mem[port.waddr] <= port.wdata;
    end
    rdata <= mem[port.raddr];
  end
endmodule
`default_nettype wire

// ----- src/directed_edge_cancel_table_top.sv -----
// Top level of the directed edge cancel table: APB register, sequencer,
// removed edge memory. Depends on dect_pkg and dect_live_mem.
//
// Usage: an item (mode, vertex_from, vertex_to) is a transfer on the in_
// channel; exactly one result (status, other_vertex, live_count,
// removed_count) follows as a transfer on the out_ channel. The block takes
// one item at a time: in_ready is low from acceptance until the result has
// been taken. Every search walks the live table through one registered
// memory read port and one shared compare, reading an entry in S_LRD
// and comparing it in S_LCMP; mode 1 then also walks the removed table
// the same way when no live reverse was found. An order-keeping removal
// moves one entry per cycle. The result register holds while out_ready
// is low. Reset zeroes both counts and swap_removal; table contents are
// not cleared and need not be.
`default_nettype none
module directed_edge_cancel_table_top
  import dect_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_mode,
  input  wire logic [15:0] in_vertex_from,
  input  wire logic [15:0] in_vertex_to,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [15:0]      out_other_vertex,
  output logic [10:0]      out_live_count,
  output logic [10:0]      out_removed_count
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LRD = 4'd1;
  localparam logic [3:0] S_LCMP = 4'd2;
  localparam logic [3:0] S_RRD = 4'd3;
  localparam logic [3:0] S_RCMP = 4'd4;
  localparam logic [3:0] S_DECIDE = 4'd5;
  localparam logic [3:0] S_SRD = 4'd6;
  localparam logic [3:0] S_SWR = 4'd7;
  localparam logic [3:0] S_OUT = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic swap_r;
  logic [2:0] mode_r;
  vtx_t a_r, b_r;
  logic [CntW-1:0] live_tot_r, live_tot_nxt, rem_tot_r, rem_tot_nxt;
  logic [CntW-1:0] idx_r, idx_nxt;
  logic rev_hit_r, rev_hit_nxt, fwd_hit_r, fwd_hit_nxt, rem_hit_r, rem_hit_nxt;
  logic [AddrW-1:0] hit_idx_r, hit_idx_nxt;
  logic [2:0] status_r, status_nxt;
  vtx_t other_r, other_nxt;
  logic out_valid_r, out_valid_nxt;
  live_port_t lport;
  live_t lrd;
  logic [2*VertexBits-1:0] rem_mem [TableDepth];
  logic [2*VertexBits-1:0] rrd;
  logic rwe;
  logic [AddrW-1:0] rraddr;
  logic wr_cfg;

  assign pready = 1'b1;
  assign wr_cfg = psel && penable && pwrite && (paddr == 2'd0);
  assign prdata = {31'd0, swap_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_r <= 1'b0;
    end else if (wr_cfg) begin
      swap_r <= pwdata[0];
    end
  end

  dect_live_mem u_live (.clk(clk), .port(lport), .rdata(lrd));

  always_ff @(posedge clk) begin
    if (rwe) begin
      rem_mem[rem_tot_r[AddrW-1:0]] <= {lrd.from, lrd.to};
    end
    rrd <= rem_mem[rraddr];
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_status = status_r;
  assign out_other_vertex = 16'(other_r);
  assign out_live_count = 11'(live_tot_r);
  assign out_removed_count = 11'(rem_tot_r);

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_r <= in_mode;
      a_r <= in_vertex_from[VertexBits-1:0];
      b_r <= in_vertex_to[VertexBits-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    live_tot_nxt = live_tot_r;
    rem_tot_nxt = rem_tot_r;
    idx_nxt = idx_r;
    rev_hit_nxt = rev_hit_r;
    fwd_hit_nxt = fwd_hit_r;
    rem_hit_nxt = rem_hit_r;
    hit_idx_nxt = hit_idx_r;
    status_nxt = status_r;
    other_nxt = other_r;
    out_valid_nxt = out_valid_r;
    lport.we = 1'b0;
    lport.waddr = idx_r[AddrW-1:0];
    lport.wdata = lrd;
    lport.raddr = idx_r[AddrW-1:0];
    rwe = 1'b0;
    rraddr = idx_r[AddrW-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          idx_nxt = '0;
          rev_hit_nxt = 1'b0;
          fwd_hit_nxt = 1'b0;
          rem_hit_nxt = 1'b0;
          other_nxt = '0;
          if (in_mode == MODE_CLEAR) begin
            live_tot_nxt = '0;
            rem_tot_nxt = '0;
            status_nxt = ST_IGNORED;
            state_nxt = S_OUT;
          end else if (in_mode > MODE_CLEAR) begin
            status_nxt = ST_IGNORED;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_LRD;
          end
        end
      end
      S_LRD: begin
        if (idx_r >= live_tot_r) begin
          if (mode_r == MODE_NEXT) begin
            status_nxt = ST_NONE;
            state_nxt = S_OUT;
          end else if (mode_r == MODE_ADD_NR && !rev_hit_r) begin
            idx_nxt = '0;
            state_nxt = S_RRD;
          end else begin
            state_nxt = S_DECIDE;
          end
        end else begin
          state_nxt = S_LCMP;
        end
      end
      S_LCMP: begin
        idx_nxt = idx_r + 1'b1;
        state_nxt = S_LRD;
        if (mode_r == MODE_NEXT) begin
          if (!lrd.visited && (lrd.from == a_r || lrd.to == a_r)) begin
            lport.we = 1'b1;
            lport.wdata = '{from: lrd.from, to: lrd.to, visited: 1'b1};
            other_nxt = (lrd.from == a_r) ? lrd.to : lrd.from;
            status_nxt = ST_FOUND;
            state_nxt = S_OUT;
          end
        end else begin
          if (!rev_hit_r && lrd.from == b_r && lrd.to == a_r) begin
            rev_hit_nxt = 1'b1;
            hit_idx_nxt = idx_r[AddrW-1:0];
            if (mode_r != MODE_ADD_ABSENT) begin
              idx_nxt = live_tot_r;
            end
          end
          if (lrd.from == a_r && lrd.to == b_r) begin
            fwd_hit_nxt = 1'b1;
          end
        end
      end
      S_RRD: begin
        if (idx_r >= rem_tot_r || rem_hit_r) begin
          state_nxt = S_DECIDE;
        end else begin
          state_nxt = S_RCMP;
        end
      end
      S_RCMP: begin
        idx_nxt = idx_r + 1'b1;
        state_nxt = S_RRD;
        if (rrd == {a_r, b_r} || rrd == {b_r, a_r}) begin
          rem_hit_nxt = 1'b1;
        end
      end
      S_DECIDE: begin
        state_nxt = S_OUT;
        lport.raddr = hit_idx_r;
        if (rev_hit_r && (mode_r == MODE_ADD || mode_r == MODE_ADD_NR)) begin
          if (rem_tot_r >= CntW'(TableDepth)) begin
            status_nxt = ST_FULL;
          end else begin
            status_nxt = ST_CANCELLED;
            idx_nxt = {1'b0, hit_idx_r};
            state_nxt = S_SRD;
          end
        end else if (rev_hit_r || (mode_r == MODE_ADD_ABSENT && fwd_hit_r) ||
                     rem_hit_r) begin
          status_nxt = ST_IGNORED;
        end else if (live_tot_r >= CntW'(TableDepth)) begin
          status_nxt = ST_FULL;
        end else begin
          lport.we = 1'b1;
          lport.waddr = live_tot_r[AddrW-1:0];
          lport.wdata = '{from: a_r, to: b_r, visited: 1'b0};
          live_tot_nxt = live_tot_r + 1'b1;
          status_nxt = ST_APPENDED;
        end
      end
      S_SRD: begin
        // lrd holds the cancelled entry here; record it, then fill the hole.
        rwe = 1'b1;
        rem_tot_nxt = rem_tot_r + 1'b1;
        live_tot_nxt = live_tot_r - 1'b1;
        if (swap_r) begin
          lport.raddr = live_tot_nxt[AddrW-1:0];
        end else begin
          lport.raddr = AddrW'(idx_r + 1'b1);
        end
        state_nxt = (idx_r + 1'b1 >= live_tot_r) ? S_OUT : S_SWR;
      end
      S_SWR: begin
        lport.we = 1'b1;
        lport.waddr = idx_r[AddrW-1:0];
        lport.wdata = lrd;
        idx_nxt = idx_r + 1'b1;
        lport.raddr = AddrW'(idx_r + 2'd2);
        if (swap_r || idx_r + 2'd2 > live_tot_r) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_SWR;
        end
      end
      S_OUT: begin
        out_valid_nxt = 1'b1;
        if (out_valid_r && out_ready) begin
          out_valid_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      live_tot_r <= '0;
      rem_tot_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      live_tot_r <= live_tot_nxt;
      rem_tot_r <= rem_tot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    rev_hit_r <= rev_hit_nxt;
    fwd_hit_r <= fwd_hit_nxt;
    rem_hit_r <= rem_hit_nxt;
    hit_idx_r <= hit_idx_nxt;
    status_r <= status_nxt;
    other_r <= other_nxt;
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    live_tot_r <= CntW'(TableDepth) && rem_tot_r <= CntW'(TableDepth))
    else $error("table count out of range");
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_live_count))
    else $error("result dropped under stall");
endmodule
`default_nettype wire

// ----- tb/tb_directed_edge_cancel_table_top.sv -----
// Testbench for the directed edge cancel table: models both edge tables,
// drives items through the in_ channel and checks every out_ transfer.
// Depends on dect_pkg and directed_edge_cancel_table_top.
`timescale 1ns / 100ps
module tb_directed_edge_cancel_table_top
  import dect_pkg::*;
();

  localparam int StallLimit = 200000;
  localparam logic [1:0] REG_SWAP_REMOVAL = 2'd0;

  typedef struct packed {
    logic [2:0] status;
    logic [15:0] other_vertex;
    logic [10:0] live_count;
    logic [10:0] removed_count;
  } edge_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_mode = '0;
  logic [15:0] in_vertex_from = '0, in_vertex_to = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_status;
  logic [15:0] out_other_vertex;
  logic [10:0] out_live_count, out_removed_count;

  live_t live_tab[TableDepth];
  vtx_t dead_from[TableDepth];
  vtx_t dead_to[TableDepth];
  int live_n, dead_n;
  logic swap_mode;
  edge_result_t pending_results[$];
  int fail_count, result_count, idle_cycles;
  int status_seen[8];

  always #2 clk = ~clk;

  directed_edge_cancel_table_top uut (
    .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_vertex_from(in_vertex_from), .in_vertex_to(in_vertex_to),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_other_vertex(out_other_vertex), .out_live_count(out_live_count),
    .out_removed_count(out_removed_count)
  );

  function automatic int find_live_edge(vtx_t f, vtx_t t);
    for (int i = 0; i < live_n; i++)
      if (live_tab[i].from == f && live_tab[i].to == t) return i;
    return -1;
  endfunction

  function automatic bit is_cancelled(vtx_t a, vtx_t b);
    for (int i = 0; i < dead_n; i++)
      if ((dead_from[i] == a && dead_to[i] == b) || (dead_from[i] == b && dead_to[i] == a))
        return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [2:0] append_live(vtx_t a, vtx_t b);
    if (live_n >= TableDepth) return ST_FULL;
    live_tab[live_n] = '{from: a, to: b, visited: 1'b0};
    live_n++;
    return ST_APPENDED;
  endfunction

  function automatic logic [2:0] cancel_live(int idx);
    if (dead_n >= TableDepth) return ST_FULL;
    dead_from[dead_n] = live_tab[idx].from;
    dead_to[dead_n] = live_tab[idx].to;
    dead_n++;
    if (swap_mode) begin
      live_n--;
      if (idx < live_n) live_tab[idx] = live_tab[live_n];
    end else begin
      for (int i = idx; i + 1 < live_n; i++) live_tab[i] = live_tab[i + 1];
      live_n--;
    end
    return ST_CANCELLED;
  endfunction

  function automatic edge_result_t predict_edge_op(logic [2:0] m, vtx_t a, vtx_t b);
    edge_result_t r;
    int idx;
    r = '0;
    r.status = ST_IGNORED;
    case (m)
      MODE_ADD: begin
        idx = find_live_edge(b, a);
        r.status = (idx >= 0) ? cancel_live(idx) : append_live(a, b);
      end
      MODE_ADD_NR: begin
        idx = find_live_edge(b, a);
        if (idx >= 0) r.status = cancel_live(idx);
        else if (!is_cancelled(a, b)) r.status = append_live(a, b);
      end
      MODE_ADD_NOREV: begin
        if (find_live_edge(b, a) < 0) r.status = append_live(a, b);
      end
      MODE_ADD_ABSENT: begin
        if (find_live_edge(b, a) < 0 && find_live_edge(a, b) < 0)
          r.status = append_live(a, b);
      end
      MODE_NEXT: begin
        r.status = ST_NONE;
        for (int i = 0; i < live_n; i++) begin
          if (!live_tab[i].visited && (live_tab[i].from == a || live_tab[i].to == a)) begin
            live_tab[i].visited = 1'b1;
            r.other_vertex = (live_tab[i].from == a) ? live_tab[i].to : live_tab[i].from;
            r.status = ST_FOUND;
            break;
          end
        end
      end
      MODE_CLEAR: begin
        live_n = 0;
        dead_n = 0;
      end
      default: ;
    endcase
    r.live_count = live_n[10:0];
    r.removed_count = dead_n[10:0];
    return r;
  endfunction

  task automatic send_edge_op(logic [2:0] m, vtx_t a, vtx_t b);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap + 1) @(posedge clk);
    in_valid <= 1'b1;
    in_mode <= m;
    in_vertex_from <= a;
    in_vertex_to <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_edge_op(m, a, b));
    in_valid <= 1'b0;
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_swap_removal(logic v);
    drain_results();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= REG_SWAP_REMOVAL;
    pwdata <= {31'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    swap_mode = v;
  endtask

  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      edge_result_t exp_r;
      result_count++;
      status_seen[out_status]++;
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected");
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_status !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, out_status);
          fail_count++;
        end
        if (out_other_vertex !== exp_r.other_vertex) begin
          $error("other_vertex expected %0d actual %0d", exp_r.other_vertex,
                 out_other_vertex);
          fail_count++;
        end
        if (out_live_count !== exp_r.live_count) begin
          $error("live_count expected %0d actual %0d", exp_r.live_count, out_live_count);
          fail_count++;
        end
        if (out_removed_count !== exp_r.removed_count) begin
          $error("removed_count expected %0d actual %0d", exp_r.removed_count,
                 out_removed_count);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ($urandom_range(0, 19) == 0) out_ready <= 1'b0;
    else if (!out_ready && $urandom_range(0, 3) != 0 && $urandom_range(0, 15) != 0)
      out_ready <= out_ready;
    else out_ready <= 1'b1;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= StallLimit) begin
      $display("tb_directed_edge_cancel_table_top: errors");
      $finish;
    end
  end

  task automatic test_directed_edges();
    send_edge_op(MODE_ADD, 16'd1, 16'd2);
    send_edge_op(MODE_ADD, 16'd2, 16'd3);
    send_edge_op(MODE_ADD, 16'hFFFF, 16'h0000);
    send_edge_op(MODE_ADD, 16'd3, 16'd1);
    send_edge_op(MODE_ADD, 16'd2, 16'd1);
    send_edge_op(MODE_ADD_NR, 16'd1, 16'd2);
    send_edge_op(MODE_ADD_NR, 16'd2, 16'd1);
    send_edge_op(MODE_ADD_NR, 16'd5, 16'd6);
    send_edge_op(MODE_ADD_NR, 16'd6, 16'd5);
    send_edge_op(MODE_ADD_NOREV, 16'd1, 16'd3);
    send_edge_op(MODE_ADD_NOREV, 16'd9, 16'd9);
    send_edge_op(MODE_ADD_ABSENT, 16'd3, 16'd1);
    send_edge_op(MODE_ADD_ABSENT, 16'd7, 16'd8);
    send_edge_op(MODE_NEXT, 16'd3, 16'hAAAA);
    send_edge_op(MODE_NEXT, 16'd3, 16'd0);
    send_edge_op(MODE_NEXT, 16'd3, 16'd0);
    send_edge_op(MODE_NEXT, 16'h0000, 16'd0);
    send_edge_op(MODE_NEXT, 16'h1234, 16'd0);
    send_edge_op(3'd6, 16'd1, 16'd2);
    send_edge_op(3'd7, 16'h5555, 16'hAAAA);
    send_edge_op(MODE_CLEAR, 16'hFFFF, 16'hFFFF);
  endtask

  task automatic test_random_mesh(logic swap, int n);
    vtx_t a, b;
    int pick;
    write_swap_removal(swap);
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      a = 16'($urandom_range(0, 11));
      b = 16'($urandom_range(0, 11));
      if (pick < 8) begin
        a = 16'($urandom);
        b = 16'($urandom);
      end
      if (pick < 45) send_edge_op(MODE_ADD, a, b);
      else if (pick < 60) send_edge_op(MODE_ADD_NR, a, b);
      else if (pick < 68) send_edge_op(MODE_ADD_NOREV, a, b);
      else if (pick < 76) send_edge_op(MODE_ADD_ABSENT, a, b);
      else if (pick < 96) send_edge_op(MODE_NEXT, a, 16'($urandom));
      else if (pick < 98) send_edge_op(MODE_CLEAR, 16'($urandom), 16'($urandom));
      else send_edge_op(3'($urandom_range(6, 7)), a, b);
    end
  endtask

  initial begin
    live_n = 0;
    dead_n = 0;
    swap_mode = 1'b0;
    fail_count = 0;
    result_count = 0;
    idle_cycles = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_edges();
    test_random_mesh(1'b0, 200);
    drain_results();
    test_random_mesh(1'b1, 200);
    test_random_mesh(1'b0, 150);
    drain_results();
    $display("Covered %0d results over both removal schemes and every mode.",
             result_count);
    $display("Status counts: app %0d canc %0d ign %0d full %0d found %0d none %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    if (fail_count == 0) $display("tb_directed_edge_cancel_table_top: clean");
    else $display("tb_directed_edge_cancel_table_top: errors");
    $finish;
  end
endmodule
